/* rtl/rme_pkg.sv */
// Package: shared types, constants and CORDIC angle table for the Euler angle block.
`default_nettype none
package rme_pkg;
   localparam int ANG_W = 25;
   localparam int CRD_W = 36;
   localparam logic signed [ANG_W-1:0] PI_INT = 25'sd6588397;
   localparam logic signed [16:0] PI_OUT = 17'sd25736;
   localparam logic signed [16:0] HALF_PI_OUT = 17'sd12868;
   localparam int TABLE_LEN = 24;

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic        lock;
      logic        neg;
      logic signed [16:0] r20;
   } side_type;

   function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] i);
      logic signed [ANG_W-1:0] r;
      begin
         case (i)
            5'd0: r = 25'sd1647099;
            5'd1: r = 25'sd972340;
            5'd2: r = 25'sd513757;
            5'd3: r = 25'sd260791;
            5'd4: r = 25'sd130902;
            5'd5: r = 25'sd65515;
            5'd6: r = 25'sd32765;
            5'd7: r = 25'sd16384;
            5'd8: r = 25'sd8192;
            5'd9: r = 25'sd4096;
            5'd10: r = 25'sd2048;
            5'd11: r = 25'sd1024;
            5'd12: r = 25'sd512;
            5'd13: r = 25'sd256;
            5'd14: r = 25'sd128;
            5'd15: r = 25'sd64;
            5'd16: r = 25'sd32;
            5'd17: r = 25'sd16;
            5'd18: r = 25'sd8;
            5'd19: r = 25'sd4;
            5'd20: r = 25'sd2;
            5'd21: r = 25'sd1;
            5'd22: r = 25'sd1;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // pre-rotate into right half plane, operands scaled by 2^16
   function automatic vec_type cordic_init(input logic signed [17:0] y,
                                           input logic signed [17:0] x);
      vec_type v;
      begin
         v.x = CRD_W'(x) <<< 16;
         v.y = CRD_W'(y) <<< 16;
         v.z = '0;
         if (x < 0) begin
            v.z = (y >= 0) ? PI_INT : -PI_INT;
            v.x = -v.x;
            v.y = -v.y;
         end
         return v;
      end
   endfunction

   function automatic logic signed [16:0] cordic_out(input logic signed [ANG_W-1:0] z);
      logic signed [ANG_W:0] s;
      logic signed [ANG_W-8:0] q;
      begin
         s = {z[ANG_W-1], z} + (ANG_W+1)'(128);
         q = s[ANG_W:8];
         if (q < -PI_OUT) return -PI_OUT;
         if (q > PI_OUT) return PI_OUT;
         return q[16:0];
      end
   endfunction
endpackage
`default_nettype wire

/* rtl/rme_cell.sv */
// One CORDIC vectoring cell: a microrotation step with its handoff register.
`default_nettype none
module rme_cell #(
   parameter int STEP = 0
) (
   input  wire logic            clock,
   input  wire logic            en,
   input  wire rme_pkg::vec_type vin,
   output rme_pkg::vec_type     vout
);
   rme_pkg::vec_type v_ff, v_in;
   always_comb begin
      v_in = vin;
      if (vin.y > 0) begin
         v_in.x = vin.x + (vin.y >>> STEP);
         v_in.y = vin.y - (vin.x >>> STEP);
         v_in.z = vin.z + rme_pkg::atan_tab(5'(STEP));
      end else if (vin.y < 0) begin
         v_in.x = vin.x - (vin.y >>> STEP);
         v_in.y = vin.y + (vin.x >>> STEP);
         v_in.z = vin.z - rme_pkg::atan_tab(5'(STEP));
      end
   end
   always_ff @(posedge clock) begin
      if (en) v_ff <= v_in;
   end
   assign vout = v_ff;
endmodule
`default_nettype wire

/* rtl/rme_sqrt_cell.sv */
// One restoring square root cell: two radicand bits per step.
`default_nettype none
module rme_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [28:0] rem_i,
   input  wire logic [14:0] root_i,
   input  wire logic [28:0] rad_i,
   output logic [28:0]      rem_o,
   output logic [14:0]      root_o,
   output logic [28:0]      rad_o
);
   localparam int SH = 28 - 2*STEP;
   logic [28:0] rem_ff, rem_in, rad_ff;
   logic [14:0] root_ff, root_in;
   logic [30:0] trial, cur;
   logic [29:0] rad_pad;
   always_comb begin
      rad_pad = {1'b0, rad_i};
      cur = {rem_i, 2'b00} | 31'(rad_pad[SH+:2]);
      trial = {14'd0, root_i, 2'b01};
      if (cur >= trial) begin
         rem_in = 29'(cur - trial);
         root_in = {root_i[13:0], 1'b1};
      end else begin
         rem_in = cur[28:0];
         root_in = {root_i[13:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         rad_ff <= rad_i;
      end
   end
   assign rem_o = rem_ff;
   assign root_o = root_ff;
   assign rad_o = rad_ff;
endmodule
`default_nettype wire

/* rtl/rotation_matrix_to_euler_top.sv */
// Top level: pipelined ZYX Euler angle extraction from a rotation matrix.
//  channel | dir | handshake              | payload
//  req     | in  | req_valid / req_ready  | req_r00..req_r22
//  rsp     | out | rsp_valid / rsp_ready  | rsp_psi_first..rsp_gimbal_lock
// Pipeline: input register, 15 square root cells, CORDIC input register, CORDIC_STAGES
// CORDIC cells (capped at 24), output register.
// One request per cycle unless the output stalls; the whole pipe advances when the output stage is free.
// Reset clears the valid bits only; a stalled output freezes all cells.
`default_nettype none
module rotation_matrix_to_euler_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic signed [15:0] req_r00,
   input  wire logic signed [15:0] req_r01,
   input  wire logic signed [15:0] req_r02,
   input  wire logic signed [15:0] req_r10,
   input  wire logic signed [15:0] req_r20,
   input  wire logic signed [15:0] req_r21,
   input  wire logic signed [15:0] req_r22,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_psi_first,
   output logic signed [14:0] rsp_theta_first,
   output logic signed [15:0] rsp_phi_first,
   output logic signed [15:0] rsp_psi_second,
   output logic        [15:0] rsp_theta_second,
   output logic signed [15:0] rsp_phi_second,
   output logic               rsp_gimbal_lock
);
   localparam int NS = (CORDIC_STAGES < rme_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                            : rme_pkg::TABLE_LEN;
   localparam int SQ = 15;
   localparam int DEPTH = 1 + SQ + 1 + NS;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic en;
   logic out_vld_ff;
   assign en = !out_vld_ff || rsp_ready;
   assign req_ready = en;
   always_comb vld_in = {vld_ff[DEPTH-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
         out_vld_ff <= vld_ff[DEPTH-1];
      end
   end

   // stage 0: saturate r20, form radicand
   logic signed [16:0] r20s;
   logic signed [33:0] r20sq;
   logic [28:0] rad;
   always_comb begin
      if (req_r20 > 16'sd16384) r20s = 17'sd16384;
      else if (req_r20 < -16'sd16384) r20s = -17'sd16384;
      else r20s = 17'(req_r20);
      r20sq = r20s * r20s;
      rad = 29'd268435456 - r20sq[28:0];
   end

   // stage 0 registers and delay line for side data
   logic [28:0] rad0_ff;
   logic signed [16:0] ad_ff [SQ+1][6];
   rme_pkg::side_type sd_ff [SQ+1];
   always_ff @(posedge clock) begin
      if (en) begin
         rad0_ff <= rad;
         sd_ff[0].r20 <= r20s;
         sd_ff[0].lock <= (r20s == 17'sd16384) || (r20s == -17'sd16384);
         sd_ff[0].neg <= r20s < 0;
         ad_ff[0][0] <= 17'(req_r21); ad_ff[0][1] <= 17'(req_r22);
         ad_ff[0][2] <= 17'(req_r10); ad_ff[0][3] <= 17'(req_r00);
         ad_ff[0][4] <= 17'(req_r01); ad_ff[0][5] <= 17'(req_r02);
         for (int k = 0; k < SQ; k++) begin
            ad_ff[k+1] <= ad_ff[k];
            sd_ff[k+1] <= sd_ff[k];
         end
      end
   end

   // square root cells
   logic [28:0] rem_c [SQ+1];
   logic [14:0] root_c [SQ+1];
   logic [28:0] rad_c [SQ+1];
   assign rem_c[0] = '0;
   assign root_c[0] = '0;
   assign rad_c[0] = rad0_ff;
   for (genvar k = 0; k < SQ; k++) begin : g_sq
      rme_sqrt_cell #(.STEP(k)) u_sq (
         .clock(clock), .en(en),
         .rem_i(rem_c[k]), .root_i(root_c[k]), .rad_i(rad_c[k]),
         .rem_o(rem_c[k+1]), .root_o(root_c[k+1]), .rad_o(rad_c[k+1]));
   end

   // five atan2 operand pairs: pitch, psi1, phi1, psi2, phi2
   rme_pkg::vec_type v0_ff [5];
   rme_pkg::vec_type v_c [5][NS+1];
   rme_pkg::side_type sdc_ff [NS+1];
   always_ff @(posedge clock) begin
      if (en) begin
         sdc_ff[0] <= sd_ff[SQ];
         for (int s = 0; s < NS; s++) sdc_ff[s+1] <= sdc_ff[s];
         v0_ff[0] <= rme_pkg::cordic_init(18'(sd_ff[SQ].r20), {3'b000, root_c[SQ]});
         if (sd_ff[SQ].lock) begin
            if (sd_ff[SQ].neg)
               v0_ff[1] <= rme_pkg::cordic_init(18'(ad_ff[SQ][4]), 18'(ad_ff[SQ][5]));
            else
               v0_ff[1] <= rme_pkg::cordic_init(-18'(ad_ff[SQ][4]), -18'(ad_ff[SQ][5]));
         end else begin
            v0_ff[1] <= rme_pkg::cordic_init(18'(ad_ff[SQ][0]), 18'(ad_ff[SQ][1]));
         end
         v0_ff[2] <= rme_pkg::cordic_init(18'(ad_ff[SQ][2]), 18'(ad_ff[SQ][3]));
         v0_ff[3] <= rme_pkg::cordic_init(-18'(ad_ff[SQ][0]), -18'(ad_ff[SQ][1]));
         v0_ff[4] <= rme_pkg::cordic_init(-18'(ad_ff[SQ][2]), -18'(ad_ff[SQ][3]));
      end
   end
   for (genvar l = 0; l < 5; l++) begin : g_lane
      assign v_c[l][0] = v0_ff[l];
      for (genvar s = 0; s < NS; s++) begin : g_st
         rme_cell #(.STEP(s)) u_cell (.clock(clock), .en(en),
            .vin(v_c[l][s]), .vout(v_c[l][s+1]));
      end
   end

   // output stage
   logic signed [16:0] z0, z1, z2, z3, z4, th1;
   always_comb begin
      z0 = rme_pkg::cordic_out(v_c[0][NS].z);
      z1 = rme_pkg::cordic_out(v_c[1][NS].z);
      z2 = rme_pkg::cordic_out(v_c[2][NS].z);
      z3 = rme_pkg::cordic_out(v_c[3][NS].z);
      z4 = rme_pkg::cordic_out(v_c[4][NS].z);
      if (sdc_ff[NS].lock)
         th1 = sdc_ff[NS].neg ? rme_pkg::HALF_PI_OUT : -rme_pkg::HALF_PI_OUT;
      else if (-z0 > rme_pkg::HALF_PI_OUT) th1 = rme_pkg::HALF_PI_OUT;
      else if (-z0 < -rme_pkg::HALF_PI_OUT) th1 = -rme_pkg::HALF_PI_OUT;
      else th1 = -z0;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_psi_first <= z1[15:0];
         rsp_theta_first <= th1[14:0];
         rsp_gimbal_lock <= sdc_ff[NS].lock;
         if (sdc_ff[NS].lock) begin
            rsp_phi_first <= '0;
            rsp_psi_second <= '0;
            rsp_theta_second <= '0;
            rsp_phi_second <= '0;
         end else begin
            rsp_phi_first <= z2[15:0];
            rsp_psi_second <= z3[15:0];
            rsp_theta_second <= 16'(rme_pkg::PI_OUT - th1);
            rsp_phi_second <= z4[15:0];
         end
      end
   end
   assign rsp_valid = out_vld_ff;

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_psi_first))
      else $error("response changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready mismatch");
   a_lock_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gimbal_lock |-> rsp_theta_second == 16'd0 && rsp_phi_first == 16'sd0)
      else $error("lock outputs not zero");
   a_theta_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gimbal_lock |->
         17'(rsp_theta_second) + 17'(rsp_theta_first) == 17'd25736)
      else $error("second pitch mismatch");
`endif
endmodule
`default_nettype wire
